[rtl/core/dzcf_pkg.sv]
// ----------------------------------------------------------------------------
// Descending zero-crossing finder package
// Word types and constants that the core and its checker share.
// ----------------------------------------------------------------------------
package dzcf_pkg;

    localparam int unsigned RADIUS_W = 32;
    localparam int unsigned GRAD_W   = 32;
    localparam int unsigned COUNT_W  = 12;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [RADIUS_W-1:0]        radius;
        logic signed [GRAD_W-1:0]   gradient;
        logic                       last_sample;
    } t_sample;

    typedef struct packed {
        logic                       crossing_found;
        logic [RADIUS_W-1:0]        crossing_radius;
        logic [COUNT_W-1:0]         crossing_count;
        logic                       frame_end;
    } t_result;

endpackage

[rtl/core/descending_zero_crossing_finder.sv]
// ----------------------------------------------------------------------------
// Descending zero-crossing finder
// Finds falling zero crossings of a gradient along a radial grid and
// interpolates the zero radius with a single multiply and serial divider.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                                Word
// sample    in         i_in_valid, o_in_ready, i_in_word      t_sample
// result    out        o_out_valid, i_out_ready, o_out_word   t_result
//
// A sample without a crossing goes from acceptance straight to S_DONE,
// which writes its result into the output register.
// A crossing passes through S_MUL for one multiply, then S_DIV for
// 32 restoring divide steps that produce one quotient bit each, then S_DONE
// to form the radius. S_DONE waits while a stalled result holds the register.
// One sample is in work at a time; the next is accepted once S_DONE is left.
// Reset clears the stored sample, the count and all handshake state.
// A stalled result waits in the output register while the next sample is
// accepted and worked on.
module descending_zero_crossing_finder
    import dzcf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_sample i_in_word,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [RADIUS_W-1:0]      r_prev_radius;
    logic signed [GRAD_W-1:0] r_prev_gradient;
    logic                     r_have_prev;
    logic [COUNT_W-1:0]       r_total;

    logic [GRAD_W-2:0]        r_num;
    logic [RADIUS_W-1:0]      r_dr;
    logic [RADIUS_W-1:0]      r_den;
    logic [RADIUS_W-1:0]      r_base;
    logic                     r_sub;
    logic                     r_found;
    logic [COUNT_W-1:0]       r_cnt;
    logic                     r_last;
    logic [RADIUS_W-1:0]      r_rem;
    logic [RADIUS_W-1:0]      r_quo;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     w_accept;
    logic                     n_found;
    logic [COUNT_W-1:0]       n_total;
    logic [GRAD_W-1:0]        n_diff;
    logic [2*RADIUS_W-2:0]    n_prod;
    logic [RADIUS_W:0]        n_trial;
    logic [RADIUS_W:0]        n_shift;
    logic [RADIUS_W-1:0]      n_radius;
    logic                     w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_found = r_have_prev && !r_prev_gradient[GRAD_W-1]
                  && (i_in_word.gradient[GRAD_W-1] || (i_in_word.gradient == '0))
                  && (r_prev_gradient > i_in_word.gradient);
        if (n_found && (r_total != COUNT_MAX)) begin
            n_total = r_total + 1'b1;
        end else begin
            n_total = r_total;
        end
        n_diff  = r_prev_gradient - i_in_word.gradient;
        n_prod  = r_num * r_dr;
        n_shift = {r_rem, r_quo[RADIUS_W-1]};
        n_trial = n_shift - {1'b0, r_den};
        if (!r_found) begin
            n_radius = '0;
        end else if (r_sub) begin
            n_radius = r_base - r_quo;
        end else begin
            n_radius = r_base + r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_prev_radius   <= '0;
            r_prev_gradient <= '0;
            r_have_prev     <= 1'b0;
            r_total         <= '0;
            r_out_valid     <= 1'b0;
            r_step          <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_found <= n_found;
                        r_cnt   <= n_total;
                        r_last  <= i_in_word.last_sample;
                        r_num   <= r_prev_gradient[GRAD_W-2:0];
                        r_den   <= n_diff;
                        r_base  <= r_prev_radius;
                        r_sub   <= (i_in_word.radius < r_prev_radius);
                        if (i_in_word.radius < r_prev_radius) begin
                            r_dr <= r_prev_radius - i_in_word.radius;
                        end else begin
                            r_dr <= i_in_word.radius - r_prev_radius;
                        end
                        if (i_in_word.last_sample) begin
                            r_prev_radius   <= '0;
                            r_prev_gradient <= '0;
                            r_have_prev     <= 1'b0;
                            r_total         <= '0;
                        end else begin
                            r_prev_radius   <= i_in_word.radius;
                            r_prev_gradient <= i_in_word.gradient;
                            r_have_prev     <= 1'b1;
                            r_total         <= n_total;
                        end
                        r_state <= n_found ? S_MUL : S_DONE;
                    end
                end
                S_MUL: begin
                    r_rem   <= {1'b0, n_prod[2*RADIUS_W-2:RADIUS_W]};
                    r_quo   <= n_prod[RADIUS_W-1:0];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!n_trial[RADIUS_W]) begin
                        r_rem <= n_trial[RADIUS_W-1:0];
                        r_quo <= {r_quo[RADIUS_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_shift[RADIUS_W-1:0];
                        r_quo <= {r_quo[RADIUS_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.crossing_found  <= r_found;
                        r_out.crossing_radius <= n_radius;
                        r_out.crossing_count  <= r_cnt;
                        r_out.frame_end       <= r_last;
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[rtl/core/dzcf_checker.sv]
// ----------------------------------------------------------------------------
// Descending zero-crossing finder checker
// Port-level checks on the finder, attached to every instance by bind.
// ----------------------------------------------------------------------------
module dzcf_checker
    import dzcf_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_ready,
    input t_sample i_in_word,
    input logic    o_out_valid,
    input logic    i_out_ready,
    input t_result o_out_word
);

    // A sample keeps the core busy in the cycle after its acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("core ready right after accepting a word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed or dropped");

    a_no_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.crossing_found) |-> (o_out_word.crossing_radius == '0))
        else $error("nonzero radius without a crossing");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.crossing_found) |-> (o_out_word.crossing_count != '0))
        else $error("crossing reported with zero count");

endmodule

bind descending_zero_crossing_finder dzcf_checker u_dzcf_checker (.*);
